/* rtl/cckb_pkg.sv */
// ----------------------------------------------------------------------------
// cckb_pkg
// shared types, register codes and reset values for the color-key sprite blit
// ----------------------------------------------------------------------------
package cckb_pkg;

    localparam int SIDE_W   = 12;   // screen and sprite sizes, row/column counters
    localparam int POS_W    = 13;   // signed anchor position
    localparam int EDGE_W   = 14;   // signed left edge and top row after alignment
    localparam int PIX_W    = 16;
    localparam int OFF_W    = 22;
    localparam int ALIGN_W  = 2;
    localparam int IDX_W    = 3;
    localparam int CDATA_W  = 16;   // widest configuration register
    localparam int MDATA_W  = 40;   // dest_offset and pixel_out padded to bytes

    localparam int DEF_MAX_SCREEN_SIDE = 2048;
    localparam int DEF_MAX_SPRITE_SIDE = 2048;

    localparam logic [SIDE_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
    localparam logic [SIDE_W-1:0] RST_SCREEN_HEIGHT = 12'd768;
    localparam logic [PIX_W-1:0]  RST_KEY           = 16'd63519;

    typedef enum logic [IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_POS_X         = 3'd4,
        REG_POS_Y         = 3'd5,
        REG_ALIGN         = 3'd6,
        REG_KEY           = 3'd7
    } reg_idx_t;

    typedef enum logic [ALIGN_W-1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_CENTRE = 2'd1,
        ALIGN_END    = 2'd2,
        ALIGN_UNUSED = 2'd3
    } align_t;

    // placement of the sprite on the screen, derived from the registers
    typedef struct packed {
        logic [SIDE_W-1:0]        sw;
        logic [SIDE_W-1:0]        sh;
        logic [SIDE_W-1:0]        w;
        logic [SIDE_W-1:0]        h;
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;    // pos_y + h - 1
        logic [PIX_W-1:0]         key;
    } geom_t;

    // register value limited to the largest supported side
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                     input int lim);
        logic [SIDE_W:0] lim_v;
        lim_v = (SIDE_W+1)'(lim);
        return ({1'b0, v} > lim_v) ? lim_v[SIDE_W-1:0] : v;
    endfunction

endpackage

/* rtl/cckb_clip.sv */
// ----------------------------------------------------------------------------
// cckb_clip
// screen position of one sprite pixel and the clip and color-key test
// ----------------------------------------------------------------------------
module cckb_clip
(
    input  cckb_pkg::geom_t                 geom,
    input  logic [cckb_pkg::SIDE_W-1:0]     col,
    input  logic [cckb_pkg::SIDE_W-1:0]     row,
    input  logic [cckb_pkg::PIX_W-1:0]      pixel,
    output logic                            hit,
    output logic [cckb_pkg::SIDE_W-1:0]     sx,
    output logic [cckb_pkg::SIDE_W-1:0]     sy
);

    localparam int SUM_W = cckb_pkg::EDGE_W + 1;

    logic signed [SUM_W-1:0] sx_full;
    logic signed [SUM_W-1:0] sy_full;
    logic                    in_sprite;
    logic                    on_screen;

    assign sx_full = SUM_W'(geom.left) + $signed(SUM_W'(col));
    assign sy_full = SUM_W'(geom.top) - $signed(SUM_W'(row));

    assign in_sprite = (col < geom.w) && (row < geom.h);

    // sign bit clear and below the screen size on both axes
    assign on_screen = !sx_full[SUM_W-1] && !sy_full[SUM_W-1]
                    && (sx_full[SUM_W-2:0] < (SUM_W-1)'(geom.sw))
                    && (sy_full[SUM_W-2:0] < (SUM_W-1)'(geom.sh));

    assign hit = in_sprite && on_screen && (pixel != geom.key);
    assign sx  = sx_full[cckb_pkg::SIDE_W-1:0];
    assign sy  = sy_full[cckb_pkg::SIDE_W-1:0];

endmodule

/* rtl/clipped_color_key_sprite_blit.sv */
// ----------------------------------------------------------------------------
// clipped_color_key_sprite_blit
// color-key sprite blitter with per-pixel clipping to the screen
//
// channel  dir  fields (lowest bit up)                   handshake
// s_*      in   tuser: first; tdata: pixel              s_tvalid/s_tready
// m_*      out  tdata: dest_offset, pixel_out, 2'b0     m_tvalid/m_tready
// cfg_*    in   index, data                              cfg_wr_en, no wait
//
// one pixel per clock while the output is not stalled; three register stages
// (input, clip test, offset multiply-add), which each write passes in that order
// pixels that are clipped or transparent leave the pipe after the clip stage
// reset clears the counters, the pipe and loads the register reset values
// a stalled output holds its stage; earlier stages keep filling into gaps
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit
#(
    parameter int MAX_SCREEN_SIDE = cckb_pkg::DEF_MAX_SCREEN_SIDE,
    parameter int MAX_SPRITE_SIDE = cckb_pkg::DEF_MAX_SPRITE_SIDE
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cckb_pkg::PIX_W-1:0]      s_tdata,   // pixel
    input  logic [0:0]                      s_tuser,   // first

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cckb_pkg::MDATA_W-1:0]    m_tdata,   // dest_offset, pixel_out, pad

    input  logic                            cfg_wr_en,
    input  logic [cckb_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cckb_pkg::CDATA_W-1:0]    cfg_data
);

    localparam int SW = cckb_pkg::SIDE_W;
    localparam int EW = cckb_pkg::EDGE_W;
    localparam int PROD_W = 2 * SW;

    // configuration registers
    logic [SW-1:0]                 screen_width_reg;
    logic [SW-1:0]                 screen_height_reg;
    logic [SW-1:0]                 sprite_width_reg;
    logic [SW-1:0]                 sprite_height_reg;
    logic [cckb_pkg::POS_W-1:0]    pos_x_reg;
    logic [cckb_pkg::POS_W-1:0]    pos_y_reg;
    logic [cckb_pkg::ALIGN_W-1:0]  align_reg;
    logic [cckb_pkg::PIX_W-1:0]    key_reg;

    cckb_pkg::geom_t geom_reg;
    cckb_pkg::geom_t geom_next;
    logic [SW-1:0]   w_now;
    logic signed [EW-1:0] shift;

    // counters
    logic [SW-1:0] col_reg, col_next;
    logic [SW-1:0] row_reg, row_next;
    logic [SW-1:0] col_base, row_base, col_inc;

    // pipe stages
    logic                        s0_valid_reg;
    logic [cckb_pkg::PIX_W-1:0]  s0_pixel_reg;
    logic [SW-1:0]               s0_col_reg;
    logic [SW-1:0]               s0_row_reg;

    logic                        s1_valid_reg;
    logic [cckb_pkg::PIX_W-1:0]  s1_pixel_reg;
    logic [SW-1:0]               s1_sx_reg;
    logic [SW-1:0]               s1_sy_reg;

    logic                        m_valid_reg;
    logic [cckb_pkg::OFF_W-1:0]  m_offset_reg;
    logic [cckb_pkg::PIX_W-1:0]  m_pixel_reg;

    logic          hit;
    logic [SW-1:0] sx, sy;
    logic [PROD_W-1:0] offset_full;

    logic s2_ready, s1_ready, accept;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= cckb_pkg::RST_SCREEN_WIDTH;
            screen_height_reg <= cckb_pkg::RST_SCREEN_HEIGHT;
            sprite_width_reg  <= '0;
            sprite_height_reg <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            align_reg         <= cckb_pkg::ALIGN_LEFT;
            key_reg           <= cckb_pkg::RST_KEY;
        end
        else if (cfg_wr_en)
        begin
            case (cckb_pkg::reg_idx_t'(cfg_index))
                cckb_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SW-1:0];
                cckb_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SW-1:0];
                cckb_pkg::REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[SW-1:0];
                cckb_pkg::REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[SW-1:0];
                cckb_pkg::REG_POS_X: pos_x_reg <= cfg_data[cckb_pkg::POS_W-1:0];
                cckb_pkg::REG_POS_Y: pos_y_reg <= cfg_data[cckb_pkg::POS_W-1:0];
                cckb_pkg::REG_ALIGN: align_reg <= cfg_data[cckb_pkg::ALIGN_W-1:0];
                cckb_pkg::REG_KEY:   key_reg   <= cfg_data[cckb_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_now = cckb_pkg::clamp_side(sprite_width_reg, MAX_SPRITE_SIDE);

    // placement is first needed one stage after the input register
    always_comb
    begin
        geom_next.sw  = cckb_pkg::clamp_side(screen_width_reg, MAX_SCREEN_SIDE);
        geom_next.sh  = cckb_pkg::clamp_side(screen_height_reg, MAX_SCREEN_SIDE);
        geom_next.w   = w_now;
        geom_next.h   = cckb_pkg::clamp_side(sprite_height_reg, MAX_SPRITE_SIDE);
        geom_next.key = key_reg;
        case (cckb_pkg::align_t'(align_reg))
            cckb_pkg::ALIGN_CENTRE: shift = $signed(EW'(w_now >> 1));
            cckb_pkg::ALIGN_END:    shift = $signed(EW'(w_now));
            default:                shift = '0;
        endcase
        geom_next.left = EW'($signed(pos_x_reg)) - shift;
        geom_next.top  = EW'($signed(pos_y_reg)) + $signed(EW'(geom_next.h))
                       - EW'(1);
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign s2_ready = !m_valid_reg || m_tready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = !s0_valid_reg || s1_ready;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // row and column counters
    // ------------------------------------------------------------------
    always_comb
    begin
        col_base = s_tuser[0] ? '0 : col_reg;
        row_base = s_tuser[0] ? '0 : row_reg;
        col_inc  = col_base + SW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= w_now)
            begin
                col_next = '0;
                row_next = row_base + SW'(1);
            end
            else
            begin
                col_next = col_inc;
                row_next = row_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_tready)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pixel_reg <= s_tdata;
            s0_col_reg   <= col_base;
            s0_row_reg   <= row_base;
        end
    end

    // ------------------------------------------------------------------
    // clip stage
    // ------------------------------------------------------------------
    cckb_clip u_clip
    (
        .geom  (geom_reg),
        .col   (s0_col_reg),
        .row   (s0_row_reg),
        .pixel (s0_pixel_reg),
        .hit   (hit),
        .sx    (sx),
        .sy    (sy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= s0_valid_reg && hit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
        begin
            s1_pixel_reg <= s0_pixel_reg;
            s1_sx_reg    <= sx;
            s1_sy_reg    <= sy;
        end
    end

    // ------------------------------------------------------------------
    // offset stage: row * screen_width + column
    // ------------------------------------------------------------------
    assign offset_full = PROD_W'(s1_sy_reg) * PROD_W'(geom_reg.sw) + PROD_W'(s1_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s2_ready)
            m_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            m_offset_reg <= offset_full[cckb_pkg::OFF_W-1:0];
            m_pixel_reg  <= s1_pixel_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_pixel_reg, m_offset_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser[0] |=> s0_col_reg == '0 && s0_row_reg == '0)
        else $error("first pixel did not restart the counters");

    a_clip_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_sx_reg < geom_reg.sw && s1_sy_reg < geom_reg.sh)
        else $error("clipped point passed the clip stage");

    a_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> m_pixel_reg != geom_reg.key)
        else $error("transparent pixel written");

endmodule

/* sim/clipped_color_key_sprite_blit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_color_key_sprite_blit_tb
// self-checking regression for the clipped color-key sprite blitter: sprite
// pixels are streamed in with random gaps, every write is predicted from a
// local copy of the registers and the row/column counters, and each output
// transaction is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit_tb;

    localparam int QUIET_LIMIT = 3000;  // cycles with no transaction before giving up
    localparam int SETTLE_CYC  = 8;     // covers the three-stage pipe after the last write

    typedef struct packed {
        logic [cckb_pkg::OFF_W-1:0] dest_offset;
        logic [cckb_pkg::PIX_W-1:0] pixel;
    } blit_write_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [cckb_pkg::PIX_W-1:0]      s_tdata;     // pixel
    logic [0:0]                      s_tuser;     // first
    logic                            m_tvalid;
    logic                            m_tready;
    logic [cckb_pkg::MDATA_W-1:0]    m_tdata;     // dest_offset, pixel_out, pad
    logic                            cfg_wr_en;
    logic [cckb_pkg::IDX_W-1:0]      cfg_index;
    logic [cckb_pkg::CDATA_W-1:0]    cfg_data;

    // register copies and counters of the local blitter model
    logic [cckb_pkg::SIDE_W-1:0]        scr_w_reg;
    logic [cckb_pkg::SIDE_W-1:0]        scr_h_reg;
    logic [cckb_pkg::SIDE_W-1:0]        spr_w_reg;
    logic [cckb_pkg::SIDE_W-1:0]        spr_h_reg;
    logic signed [cckb_pkg::POS_W-1:0]  pos_x_reg;
    logic signed [cckb_pkg::POS_W-1:0]  pos_y_reg;
    cckb_pkg::align_t                   align_reg;
    logic [cckb_pkg::PIX_W-1:0]         key_reg;
    logic [cckb_pkg::SIDE_W-1:0]        col_pos;
    logic [cckb_pkg::SIDE_W-1:0]        row_pos;

    blit_write_t pending_writes[$];

    int fail_count     = 0;
    int pixels_sent    = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_req       = 0;
    int quiet_cycles   = 0;

    clipped_color_key_sprite_blit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp_side_int(input logic [cckb_pkg::SIDE_W-1:0] v,
                                          input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic void reset_blit_model();
        scr_w_reg = cckb_pkg::RST_SCREEN_WIDTH;
        scr_h_reg = cckb_pkg::RST_SCREEN_HEIGHT;
        spr_w_reg = '0;
        spr_h_reg = '0;
        pos_x_reg = '0;
        pos_y_reg = '0;
        align_reg = cckb_pkg::ALIGN_LEFT;
        key_reg   = cckb_pkg::RST_KEY;
        col_pos   = '0;
        row_pos   = '0;
    endfunction

    // one pixel through the model; returns 1 when it lies inside the sprite, lands on screen and is opaque
    function automatic bit predict_blit(input logic first,
                                        input logic [cckb_pkg::PIX_W-1:0] pix,
                                        output blit_write_t wr);
        int sw, sh, w, h, left, col, row, sx, sy;
        bit hit;
        sw = clamp_side_int(scr_w_reg, cckb_pkg::DEF_MAX_SCREEN_SIDE);
        sh = clamp_side_int(scr_h_reg, cckb_pkg::DEF_MAX_SCREEN_SIDE);
        w  = clamp_side_int(spr_w_reg, cckb_pkg::DEF_MAX_SPRITE_SIDE);
        h  = clamp_side_int(spr_h_reg, cckb_pkg::DEF_MAX_SPRITE_SIDE);
        left = pos_x_reg;
        if (align_reg == cckb_pkg::ALIGN_CENTRE)
            left -= w / 2;
        else if (align_reg == cckb_pkg::ALIGN_END)
            left -= w;
        if (first)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        col = col_pos;
        row = row_pos;
        sx  = left + col;
        // the sprite is stored bottom-up
        sy  = int'(pos_y_reg) + h - 1 - row;
        hit = (col < w) && (row < h) && (sx >= 0) && (sx < sw) && (sy >= 0) && (sy < sh)
              && (pix != key_reg);
        wr.dest_offset = cckb_pkg::OFF_W'(sy * sw + sx);
        wr.pixel       = pix;
        col_pos = col_pos + 1'b1;
        if (int'(col_pos) >= w)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        return hit;
    endfunction

    // back-to-back writes keep the enable high; the caller lowers it
    task automatic write_reg(input cckb_pkg::reg_idx_t idx,
                             input logic [cckb_pkg::CDATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            cckb_pkg::REG_SCREEN_WIDTH:  scr_w_reg = val[cckb_pkg::SIDE_W-1:0];
            cckb_pkg::REG_SCREEN_HEIGHT: scr_h_reg = val[cckb_pkg::SIDE_W-1:0];
            cckb_pkg::REG_SPRITE_WIDTH:  spr_w_reg = val[cckb_pkg::SIDE_W-1:0];
            cckb_pkg::REG_SPRITE_HEIGHT: spr_h_reg = val[cckb_pkg::SIDE_W-1:0];
            cckb_pkg::REG_POS_X:         pos_x_reg = val[cckb_pkg::POS_W-1:0];
            cckb_pkg::REG_POS_Y:         pos_y_reg = val[cckb_pkg::POS_W-1:0];
            cckb_pkg::REG_ALIGN:
                align_reg = cckb_pkg::align_t'(val[cckb_pkg::ALIGN_W-1:0]);
            cckb_pkg::REG_KEY:           key_reg   = val[cckb_pkg::PIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_writes();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // registers only change with the pipe empty, clipped pixels included
    task automatic set_geometry(input int sw, input int sh, input int spw, input int sph,
                                input int px, input int py, input cckb_pkg::align_t al,
                                input logic [cckb_pkg::PIX_W-1:0] key);
        drain_writes();
        repeat (SETTLE_CYC) @(posedge clk);
        write_reg(cckb_pkg::REG_SCREEN_WIDTH,  cckb_pkg::CDATA_W'(sw));
        write_reg(cckb_pkg::REG_SCREEN_HEIGHT, cckb_pkg::CDATA_W'(sh));
        write_reg(cckb_pkg::REG_SPRITE_WIDTH,  cckb_pkg::CDATA_W'(spw));
        write_reg(cckb_pkg::REG_SPRITE_HEIGHT, cckb_pkg::CDATA_W'(sph));
        write_reg(cckb_pkg::REG_POS_X,         cckb_pkg::CDATA_W'(px));
        write_reg(cckb_pkg::REG_POS_Y,         cckb_pkg::CDATA_W'(py));
        write_reg(cckb_pkg::REG_ALIGN,         cckb_pkg::CDATA_W'(al));
        write_reg(cckb_pkg::REG_KEY,           cckb_pkg::CDATA_W'(key));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic first, input logic [cckb_pkg::PIX_W-1:0] pix);
        blit_write_t wr;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
        if (predict_blit(first, pix, wr))
            pending_writes.push_back(wr);
    endtask

    function automatic int rand_screen_side();
        case ($urandom_range(15))
            0:       return 0;
            1:       return cckb_pkg::DEF_MAX_SCREEN_SIDE;
            2:       return 4095;
            3:       return 1;
            4:       return cckb_pkg::DEF_MAX_SCREEN_SIDE - 1;
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    function automatic int rand_sprite_side();
        case ($urandom_range(15))
            0:       return 0;
            1:       return cckb_pkg::DEF_MAX_SPRITE_SIDE;
            2:       return 4095;
            3:       return 1;
            default: return $urandom_range(2, 9);
        endcase
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(19))
            0:       return -4096;
            1:       return 4095;
            default: return int'($urandom_range(0, 79)) - 24;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset geometry has a zero-width sprite: every pixel moves down a row
    task automatic test_zero_sprite_width();
        send_pixel(1'b1, 16'h1357);
        send_pixel(1'b0, 16'hFFFF);
    endtask

    // full 3x2 sprite with the color key, the extreme pixel values and one
    // pixel past the last row
    task automatic test_key_and_extremes();
        set_geometry(8, 4, 3, 2, 2, 1, cckb_pkg::ALIGN_LEFT, 16'h1234);
        send_pixel(1'b1, 16'h0000);
        send_pixel(1'b0, 16'hFFFF);
        send_pixel(1'b0, 16'h1234);
        send_pixel(1'b0, 16'h8001);
        send_pixel(1'b0, 16'h7FFE);
        send_pixel(1'b0, 16'h00FF);
        send_pixel(1'b0, 16'hABCD);
    endtask

    // each alignment, with the left and the right edge clipping
    task automatic test_alignment();
        cckb_pkg::align_t al;
        al = cckb_pkg::ALIGN_LEFT;
        do
        begin
            set_geometry(4, 2, 3, 1, 2, 0, al, cckb_pkg::RST_KEY);
            send_pixel(1'b1, 16'hA5A5);
            send_pixel(1'b0, 16'h5A5A);
            send_pixel(1'b0, 16'hC3C3);
            al = al.next();
        end
        while (al != cckb_pkg::ALIGN_LEFT);
    endtask

    // sizes above the limit clamp; last pixel of the largest screen; empty screen
    task automatic test_oversized_and_empty_screen();
        set_geometry(4095, 4095, 4095, 4095, cckb_pkg::DEF_MAX_SCREEN_SIDE - 1,
                     cckb_pkg::DEF_MAX_SCREEN_SIDE - cckb_pkg::DEF_MAX_SPRITE_SIDE,
                     cckb_pkg::ALIGN_LEFT, cckb_pkg::RST_KEY);
        send_pixel(1'b1, 16'h4242);
        send_pixel(1'b0, 16'h2424);
        set_geometry(0, 8, 1, 1, 0, 0, cckb_pkg::ALIGN_LEFT, cckb_pkg::RST_KEY);
        send_pixel(1'b1, 16'h0F0F);
    endtask

    // long receiver hold-off fills the pipe; then the sender waits for it to empty
    task automatic test_backpressure();
        set_geometry(64, 64, 8, 8, 0, 0, cckb_pkg::ALIGN_LEFT, 16'h0000);
        hold_req = 300;
        for (int i = 0; i < 32; i++)
            send_pixel(i == 0, cckb_pkg::PIX_W'($urandom_range(65535, 1)));
        drain_writes();
        for (int i = 0; i < 32; i++)
            send_pixel(1'b0, cckb_pkg::PIX_W'($urandom_range(65535, 1)));
    endtask

    task automatic run_random_frame();
        int sw, sh, spw, sph, w, h, n;
        logic [cckb_pkg::PIX_W-1:0] key;
        logic [cckb_pkg::PIX_W-1:0] pix;
        logic first;
        sw  = rand_screen_side();
        sh  = rand_screen_side();
        spw = rand_sprite_side();
        sph = rand_sprite_side();
        key = ($urandom_range(3) == 0) ? cckb_pkg::RST_KEY : cckb_pkg::PIX_W'($urandom);
        set_geometry(sw, sh, spw, sph, rand_pos(), rand_pos(),
                     cckb_pkg::align_t'($urandom_range(3)), key);
        w = clamp_side_int(cckb_pkg::SIDE_W'(spw), cckb_pkg::DEF_MAX_SPRITE_SIDE);
        h = clamp_side_int(cckb_pkg::SIDE_W'(sph), cckb_pkg::DEF_MAX_SPRITE_SIDE);
        n = (w == 0) ? h : w * h;
        if (n > 48)
            n = 48;
        n += $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0, 1:    pix = key;
                2:       pix = '0;
                3:       pix = '1;
                default: pix = cckb_pkg::PIX_W'($urandom);
            endcase
            // mostly a clean frame start, now and then a stray restart
            first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(31) == 0);
            send_pixel(first, pix);
        end
    endtask

    task automatic test_random_frames(input int idle, input int stall, input int items);
        int start_px;
        idle_pct  = idle;
        stall_pct = stall;
        start_px  = pixels_sent;
        while (pixels_sent - start_px < items)
            run_random_frame();
    endtask

    // ------------------------------------------------------------------------
    // receiver, checker and watchdog
    // ------------------------------------------------------------------------

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                m_tready <= 1'b0;
                for (int i = 0; i < hold_req; i++)
                    @(posedge clk);
                hold_req = 0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        blit_write_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write transaction: dest_offset %0d pixel_out 0x%04h",
                       m_tdata[cckb_pkg::OFF_W-1:0],
                       m_tdata[cckb_pkg::OFF_W +: cckb_pkg::PIX_W]);
                fail_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (m_tdata[cckb_pkg::OFF_W-1:0] !== want.dest_offset)
                begin
                    $error("dest_offset: expected %0d, actual %0d",
                           want.dest_offset, m_tdata[cckb_pkg::OFF_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[cckb_pkg::OFF_W +: cckb_pkg::PIX_W] !== want.pixel)
                begin
                    $error("pixel_out: expected 0x%04h, actual 0x%04h",
                           want.pixel, m_tdata[cckb_pkg::OFF_W +: cckb_pkg::PIX_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("clipped_color_key_sprite_blit regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        reset_blit_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_sprite_width();
        test_key_and_extremes();
        test_alignment();
        test_oversized_and_empty_screen();
        test_backpressure();
        test_random_frames(0, 0, 500);
        test_random_frames(81, 0, 500);
        test_random_frames(0, 81, 500);
        test_random_frames(10, 10, 500);

        drain_writes();
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("clipped_color_key_sprite_blit regression: pass");
        else
            $display("clipped_color_key_sprite_blit regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/cckb_pkg.sv
rtl/cckb_clip.sv
rtl/clipped_color_key_sprite_blit.sv
sim/clipped_color_key_sprite_blit_tb.sv
